FILE: rtl/itoa_pkg.sv
`timescale 1ns / 1ps

package itoa_pkg;

    // pointer form prints the low PTR_W bits of the value
    localparam int PTR_W      = 64;
    localparam int PTR_DIGITS = (PTR_W + 3) / 4;
    localparam int DEC_DIGITS = 10;
    localparam int DIG_N      = (PTR_DIGITS > DEC_DIGITS) ? PTR_DIGITS : DEC_DIGITS;
    localparam int IDX_W      = $clog2(DIG_N);
    localparam int CNT_W      = $clog2(DIG_N + 1);
    localparam int TOTAL_W    = 31;

    localparam logic [63:0] PTR_MASK = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - PTR_W);

    // ceil(2^35 / 10); floor(v * RECIP10 / 2^35) == v / 10 for any 32-bit v
    localparam logic [31:0] RECIP10  = 32'hCCCC_CCCD;
    localparam int          RECIP_SH = 35;
    localparam int          QUOT_W   = 64 - RECIP_SH;

    localparam logic [2:0] CMD_SDEC = 3'd0;
    localparam logic [2:0] CMD_UDEC = 3'd1;
    localparam logic [2:0] CMD_HEXL = 3'd2;
    localparam logic [2:0] CMD_HEXU = 3'd3;
    localparam logic [2:0] CMD_PTR  = 3'd4;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_LOWA  = 8'h61;
    localparam logic [7:0] CH_UPA   = 8'h41;

    typedef struct packed {
        logic        start;
        logic        hex;
        logic [63:0] value;
    } t_dig_req;

    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] count;
    } t_dig_stat;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        base = upper ? CH_UPA : CH_LOWA;
        if (d < 4'd10) begin
            return CH_ZERO + {4'b0000, d};
        end
        return base + {4'b0000, d - 4'd10};
    endfunction

endpackage

FILE: rtl/itoa_digit_unit.sv
`timescale 1ns / 1ps

module itoa_digit_unit
    import itoa_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dig_req         i_req,
    input  logic [IDX_W-1:0] i_rd_idx,
    output t_dig_stat        o_stat,
    output logic [3:0]       o_rd_digit
);

    localparam logic [1:0] DS_IDLE = 2'd0;
    localparam logic [1:0] DS_MUL  = 2'd1;
    localparam logic [1:0] DS_DIV  = 2'd2;
    localparam logic [1:0] DS_HEX  = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [63:0]       r_val, n_val;
    logic [63:0]       r_prod, n_prod;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [3:0]        r_buf [DIG_N];
    logic              wr_en;
    logic [3:0]        wr_digit;

    logic [QUOT_W-1:0] quot;
    logic [3:0]        q10_lo;
    logic [3:0]        rem;
    logic [63:0]       val_sh;

    assign quot   = r_prod[63:RECIP_SH];
    // remainder < 10, so the low nibble of v - 10q is enough
    assign q10_lo = {quot[0], 3'b000} + {quot[2:0], 1'b0};
    assign rem    = r_val[3:0] - q10_lo;
    assign val_sh = r_val >> 4;

    always_comb begin
        n_state  = r_state;
        n_val    = r_val;
        n_prod   = r_prod;
        n_cnt    = r_cnt;
        wr_en    = 1'b0;
        wr_digit = rem;
        unique case (r_state)
            DS_IDLE: begin
                if (i_req.start) begin
                    n_val   = i_req.value;
                    n_cnt   = '0;
                    n_state = i_req.hex ? DS_HEX : DS_MUL;
                end
            end
            DS_MUL: begin
                n_prod  = 64'(r_val[31:0]) * 64'(RECIP10);
                n_state = DS_DIV;
            end
            DS_DIV: begin
                wr_en    = 1'b1;
                wr_digit = rem;
                n_val    = 64'(quot);
                n_cnt    = r_cnt + 1'b1;
                n_state  = (quot == '0) ? DS_IDLE : DS_MUL;
            end
            DS_HEX: begin
                wr_en    = 1'b1;
                wr_digit = r_val[3:0];
                n_val    = val_sh;
                n_cnt    = r_cnt + 1'b1;
                n_state  = (val_sh == '0) ? DS_IDLE : DS_HEX;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DS_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_val  <= n_val;
        r_prod <= n_prod;
        if (wr_en) begin
            r_buf[r_cnt[IDX_W-1:0]] <= wr_digit;
        end
    end

    assign o_stat.busy  = (r_state != DS_IDLE);
    assign o_stat.count = r_cnt;
    assign o_rd_digit   = r_buf[i_rd_idx];

endmodule

FILE: rtl/integer_to_ascii_formatter_core.sv
`timescale 1ns / 1ps

// integer to ascii formatter
// input channel (i_valid / o_ready): one item = command + 64-bit value. o_ready is
// high only while the block is idle; an item with an unknown command is dropped.
// output channel (o_valid / i_ready): one item per character, most significant
// first, o_last on the final one, o_chars_emitted = saturating running total.
// timing: digits are peeled off by one shared unit before any character goes out.
// decimal alternates a registered reciprocal multiply and a remainder step per
// digit, hex and pointer shift off one nibble per digit. after that, the first
// character is loaded into the output register, then one character per cycle
// goes out while i_ready is high.
// a stalled receiver simply holds the current character in the output
// register; nothing is lost and the next item waits.
// reset clears the sequencer, the output valid and the running total.
module integer_to_ascii_formatter_core
    import itoa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_command,
    input  logic [63:0]        i_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_character,
    output logic               o_last,
    output logic [TOTAL_W-1:0] o_chars_emitted
);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_EXTRACT = 2'd1;
    localparam logic [1:0] ST_EMIT    = 2'd2;

    logic [1:0]         r_state, n_state;
    logic               r_out_valid, n_out_valid;
    logic [7:0]         r_char, n_char;
    logic               r_last, n_last;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic [1:0]         r_pre, n_pre;
    logic               r_ptr, n_ptr;
    logic               r_upper, n_upper;
    logic [IDX_W-1:0]   r_idx, n_idx;

    t_dig_req           dig_req;
    t_dig_stat          dig_stat;
    logic [IDX_W-1:0]   cur_idx;
    logic [3:0]         rd_digit;

    logic               in_acc, out_acc, load, cmd_ok, neg;
    logic [31:0]        low, mag;

    itoa_digit_unit u_digit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (dig_req),
        .i_rd_idx   (cur_idx),
        .o_stat     (dig_stat),
        .o_rd_digit (rd_digit)
    );

    assign o_ready = (r_state == ST_IDLE);
    assign in_acc  = i_valid && o_ready;
    assign out_acc = r_out_valid && i_ready;
    assign cmd_ok  = (i_command == CMD_SDEC) || (i_command == CMD_UDEC) ||
                     (i_command == CMD_HEXL) || (i_command == CMD_HEXU) ||
                     (i_command == CMD_PTR);
    assign low     = i_value[31:0];
    assign neg     = (i_command == CMD_SDEC) && low[31];
    assign mag     = neg ? (~low + 32'd1) : low;

    always_comb begin
        dig_req.start = in_acc && cmd_ok;
        dig_req.hex   = (i_command == CMD_HEXL) || (i_command == CMD_HEXU) ||
                        (i_command == CMD_PTR);
        dig_req.value = (i_command == CMD_PTR) ? (i_value & PTR_MASK) : 64'(mag);
    end

    // first digit index comes straight from the unit's count on the load cycle
    assign cur_idx = (r_state == ST_EXTRACT) ? IDX_W'(dig_stat.count - 1'b1) : r_idx;

    assign load = ((r_state == ST_EXTRACT) && !dig_stat.busy) ||
                  ((r_state == ST_EMIT) && out_acc && !r_last);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_char      = r_char;
        n_last      = r_last;
        n_total     = r_total;
        n_pre       = r_pre;
        n_ptr       = r_ptr;
        n_upper     = r_upper;
        n_idx       = cur_idx;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && cmd_ok) begin
                    n_state = ST_EXTRACT;
                    n_ptr   = (i_command == CMD_PTR);
                    n_upper = (i_command == CMD_HEXU);
                    n_pre   = (i_command == CMD_PTR) ? 2'd2 : (neg ? 2'd1 : 2'd0);
                end
            end
            ST_EXTRACT: begin
                if (load) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_acc && r_last) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b0;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (load) begin
            n_out_valid = 1'b1;
            n_total     = (r_total == '1) ? r_total : r_total + 1'b1;
            if (r_pre != 2'd0) begin
                n_char = r_ptr ? ((r_pre == 2'd2) ? CH_ZERO : CH_X) : CH_MINUS;
                n_last = 1'b0;
                n_pre  = r_pre - 2'd1;
            end else begin
                n_char = digit_char(rd_digit, r_upper);
                n_last = (cur_idx == '0);
                n_idx  = cur_idx - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_total     <= '0;
            r_pre       <= 2'd0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_total     <= n_total;
            r_pre       <= n_pre;
        end
        r_char  <= n_char;
        r_last  <= n_last;
        r_ptr   <= n_ptr;
        r_upper <= n_upper;
        r_idx   <= n_idx;
    end

    assign o_valid         = r_out_valid;
    assign o_character     = r_char;
    assign o_last          = r_last;
    assign o_chars_emitted = r_total;

    // no new item while characters of the previous one are pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid)
        else $error("input ready while a character is pending");

    // a run continues until its last character is taken
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last |=> o_valid)
        else $error("character run broke off before last");

    // taking the last character frees the block
    a_free_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_last |=> o_ready)
        else $error("block not ready after last character");

    // running total never goes backwards
    a_total_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> o_chars_emitted >= $past(o_chars_emitted))
        else $error("character total decreased");

endmodule
